### hdl/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	localparam int TIME_W = 32;
	localparam int REM_W = 16;
	localparam int ID_W = 16;

	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch request payload, restart the scan
		logic scan;    // issue one slot read and advance the index
		logic commit;  // apply the decision and load the response register
	} srtf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // index points at the last slot
		logic rsp_free;   // response register can take a new result
	} srtf_sts_t;

endpackage

### hdl/srtf_ctrl.sv
`timescale 1ns / 1ps

module srtf_ctrl import srtf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output srtf_cmd_t cmd,
	input  srtf_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.rsp_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign cmd.load   = req_valid && (state_q == ST_IDLE);
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_COMMIT) && sts.rsp_free;

	// a scan always ends in the drain state before the commit
	a_drain_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.scan_last |=> (state_q == ST_DRAIN))
		else $error("scan did not end in drain");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("two commits in a row");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SCAN))
		else $error("load did not start a scan");

endmodule

### hdl/srtf_dp.sv
`timescale 1ns / 1ps

module srtf_dp import srtf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  srtf_cmd_t         cmd,
	output srtf_sts_t         sts,
	input  logic              kind,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [REM_W-1:0]  burst_time,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [ID_W-1:0]   task_id,
	output logic              task_done,
	output logic [TIME_W-1:0] tick_time,
	output logic              table_full
);

	// request payload
	logic              kind_q;
	logic [TIME_W-1:0] arr_q;
	logic [REM_W-1:0]  burst_q;

	// architectural state
	logic [TASK_SLOTS-1:0] slot_valid_q;
	logic [CNT_W-1:0]      valid_cnt_q;
	logic [TIME_W-1:0]     cur_time_q;
	logic [ID_W-1:0]       next_id_q;

	// slot tables
	logic [TIME_W-1:0] slot_arr_mem [TASK_SLOTS];
	logic [REM_W-1:0]  slot_rem_mem [TASK_SLOTS];
	logic [ID_W-1:0]   slot_id_mem  [TASK_SLOTS];

	// scan
	logic [SLOT_W-1:0] scan_idx_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic              slot_vld_s1;
	logic [TIME_W-1:0] rd_arr_s1;
	logic [REM_W-1:0]  rd_rem_s1;
	logic [ID_W-1:0]   rd_id_s1;

	logic              best_found_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [TIME_W-1:0] best_arr_q;
	logic [REM_W-1:0]  best_rem_q;
	logic [ID_W-1:0]   best_id_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;

	// response register
	logic              rsp_valid_q;
	logic [ID_W-1:0]   task_id_q;
	logic              task_done_q;
	logic [TIME_W-1:0] tick_time_q;
	logic              table_full_q;

	logic eligible;
	logic better;
	logic take;

	assign eligible = slot_vld_s1 && (rd_arr_s1 <= cur_time_q);
	// least remaining, then earlier arrival, then lower id; strict so lower slot wins
	assign better = {rd_rem_s1, rd_arr_s1, rd_id_s1} < {best_rem_q, best_arr_q, best_id_q};
	assign take = rd_vld_s1 && eligible && (!best_found_q || better);

	assign sts.scan_last = (scan_idx_q == SLOT_W'(TASK_SLOTS - 1));
	assign sts.rsp_free  = !rsp_valid_q || rsp_ready;

	// commit decision
	logic [ID_W-1:0]  id_inc;
	logic [ID_W-1:0]  id_next;
	logic [REM_W-1:0] rem_dec;
	logic             is_reg;
	logic             reg_zero;
	logic             reg_place;
	logic             tick_serve;
	logic             tick_finish;
	logic             id_take;
	logic [ID_W-1:0]  res_id;
	logic             res_done;
	logic [CNT_W-1:0] cnt_next;

	always_comb begin
		id_inc      = next_id_q + ID_W'(1);
		id_next     = (id_inc == '0) ? ID_W'(1) : id_inc;
		rem_dec     = (best_rem_q != '0) ? (best_rem_q - REM_W'(1)) : '0;
		is_reg      = (kind_q == KIND_REGISTER);
		reg_zero    = is_reg && (burst_q == '0);
		reg_place   = is_reg && (burst_q != '0) && (valid_cnt_q != CNT_W'(TASK_SLOTS));
		tick_serve  = !is_reg && best_found_q;
		tick_finish = tick_serve && (rem_dec == '0);
		id_take     = reg_zero || reg_place;
		res_id      = id_take ? next_id_q : (tick_serve ? best_id_q : '0);
		res_done    = reg_zero || tick_finish;
		cnt_next    = valid_cnt_q;
		if (reg_place) cnt_next = valid_cnt_q + CNT_W'(1);
		else if (tick_finish) cnt_next = valid_cnt_q - CNT_W'(1);
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			arr_q   <= arrival_time;
			burst_q <= burst_time;
		end
	end

	// slot tables: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && reg_place) begin
			slot_arr_mem[free_idx_q] <= arr_q;
			slot_rem_mem[free_idx_q] <= burst_q;
			slot_id_mem[free_idx_q]  <= next_id_q;
		end else if (cmd.commit && tick_serve && !tick_finish) begin
			slot_rem_mem[best_idx_q] <= rem_dec;
		end
		rd_arr_s1 <= slot_arr_mem[scan_idx_q];
		rd_rem_s1 <= slot_rem_mem[scan_idx_q];
		rd_id_s1  <= slot_id_mem[scan_idx_q];
		rd_idx_s1 <= scan_idx_q;
	end

	// scan control and running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			slot_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.scan;
			slot_vld_s1 <= slot_valid_q[scan_idx_q];
			if (cmd.load) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan) scan_idx_q <= scan_idx_q + SLOT_W'(1);
				if (take) best_found_q <= 1'b1;
				if (rd_vld_s1 && !slot_vld_s1) free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_arr_q <= rd_arr_s1;
			best_rem_q <= rd_rem_s1;
			best_id_q  <= rd_id_s1;
		end
		if (rd_vld_s1 && !slot_vld_s1 && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			valid_cnt_q  <= '0;
			cur_time_q   <= '0;
			next_id_q    <= ID_W'(1);
		end else if (cmd.commit) begin
			valid_cnt_q <= cnt_next;
			if (id_take) next_id_q <= id_next;
			if (reg_place) slot_valid_q[free_idx_q] <= 1'b1;
			if (tick_finish) slot_valid_q[best_idx_q] <= 1'b0;
			if (!is_reg && (cur_time_q != '1)) cur_time_q <= cur_time_q + TIME_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			task_id_q    <= res_id;
			task_done_q  <= res_done;
			tick_time_q  <= cur_time_q;
			table_full_q <= (cnt_next == CNT_W'(TASK_SLOTS));
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign task_id    = task_id_q;
	assign task_done  = task_done_q;
	assign tick_time  = tick_time_q;
	assign table_full = table_full_q;

	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		int'(valid_cnt_q) == $countones(slot_valid_q))
		else $error("occupancy count out of step with valid bits");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id is zero");

	a_served_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && tick_serve |-> (best_arr_q <= cur_time_q) && slot_valid_q[best_idx_q])
		else $error("served task not arrived or not valid");

	a_place_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && reg_place |-> free_found_q && !slot_valid_q[free_idx_q])
		else $error("placement into an occupied slot");

endmodule

### hdl/srtf_tick_scheduler_unit.sv
`timescale 1ns / 1ps

// Shortest-remaining-time-first tick scheduler. A request with kind register
// places a task (arrival_time, burst_time) in a free slot and answers with a
// new sequential id (0 when the table is full; a zero burst gets an id and
// completes at once without using a slot). A request with kind tick serves
// the arrived task with the least remaining time (ties: earlier arrival,
// then lower id, then lower slot), reports its id (0 when idle), flags
// completion and frees its slot, then advances time, which saturates at the
// all-ones value. Every request gives exactly one response; tick_time is the
// time before the request and table_full the occupancy after it.
// The controller sweeps the slot table through its single read port, one slot
// per cycle, then drains the read register and commits, which loads the
// response register. A new request is taken only in idle, once the previous
// one has committed.
// The response sits in an output register; the next request is taken while it
// waits, and only its commit stalls if the earlier response is still pending.
// No clearing pass: slot valid bits reset directly.

module srtf_tick_scheduler_unit import srtf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              kind,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [REM_W-1:0]  burst_time,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [ID_W-1:0]   task_id,
	output logic              task_done,
	output logic [TIME_W-1:0] tick_time,
	output logic              table_full
);

	srtf_cmd_t cmd;
	srtf_sts_t sts;

	// sequencing: idle -> scan -> drain -> commit
	srtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// slot tables, selection, time/id counters and the response register
	srtf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.arrival_time (arrival_time),
		.burst_time   (burst_time),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.task_id      (task_id),
		.task_done    (task_done),
		.tick_time    (tick_time),
		.table_full   (table_full)
	);

endmodule
